// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define LLS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lls assertion failed");

// next-cycle implication, checked outside reset
`define LLS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lls assertion failed");

`endif

// ===== sv/lls_pkg.sv =====
package lls_pkg;

  localparam int NODES_DEF = 16;

  localparam int ID_W     = 4;
  localparam int LOSS_W   = 16;
  localparam int WEIGHT_W = 9;
  localparam int ACC_W    = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;

  localparam logic [WEIGHT_W-1:0] EMA_WEIGHT_RST      = 9'd77;
  localparam logic [LOSS_W-1:0]   BLOCK_THRESHOLD_RST = 16'd768;
  localparam logic [LOSS_W-1:0]   CLEAR_THRESHOLD_RST = 16'd256;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EMA_WEIGHT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR_THRESHOLD = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]   node_a;
    logic [ID_W-1:0]   node_b;
    logic [LOSS_W-1:0] reported_loss;
  } item_t;

  typedef struct packed {
    logic [LOSS_W-1:0] smoothed_loss;
    logic              link_blocked;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_t;

  typedef struct packed {
    logic [LOSS_W-1:0] loss;
    logic              blocked;
  } entry_t;

  // control of the shared multiply-accumulate unit
  typedef struct packed {
    logic en;
    logic acc_clr;
  } mac_op_t;

endpackage

// ===== sv/lls_stream_if.sv =====
interface lls_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/lls_mac.sv =====
module lls_mac (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lls_pkg::mac_op_t                  op_i,
  input  logic [lls_pkg::WEIGHT_W-1:0]      mul_a_i,
  input  logic [lls_pkg::LOSS_W-1:0]        mul_b_i,
  output logic [lls_pkg::ACC_W-1:0]         acc_o
);

  logic [lls_pkg::WEIGHT_W+lls_pkg::LOSS_W-1:0] prod;
  logic [lls_pkg::ACC_W-1:0]                    acc_q, acc_d;

  // weight never exceeds 256, so the product fits the accumulator
  assign prod  = {{lls_pkg::LOSS_W{1'b0}}, mul_a_i} * {{lls_pkg::WEIGHT_W{1'b0}}, mul_b_i};
  assign acc_d = (op_i.acc_clr ? '0 : acc_q) + prod[lls_pkg::ACC_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (op_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

// ===== sv/lls_store.sv =====
module lls_store #(
  parameter int NODES = lls_pkg::NODES_DEF,
  localparam int LinkCount = NODES * NODES,
  localparam int AW = $clog2(LinkCount)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  lls_pkg::entry_t wdata_i,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_i,
  output lls_pkg::entry_t rdata_o,
  output logic            busy_o
);

  localparam logic [AW-1:0] LastAddr = AW'(LinkCount - 1);

  lls_pkg::entry_t mem_q [LinkCount];
  lls_pkg::entry_t rdata_q;
  logic            clr_busy_q;
  logic [AW-1:0]   clr_addr_q;

  // zeroing sweep after reset, one entry per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      if (clr_addr_q == LastAddr) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_addr_q] <= '0;
    end else if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = clr_busy_q;

endmodule

// ===== sv/link_loss_smoother_hysteresis.sv =====
// channel  | dir | payload                                   | handshake
// item_i   | in  | node_a, node_b, reported_loss             | valid/ready
// result_o | out | smoothed_loss, link_blocked               | valid/ready
// cfg_i    | in  | index, wdata                              | valid/ready, always ready
//
// a transaction steps through accept, table read, two passes through the
// shared 9x16 multiply-accumulate unit, then table write and result load
// the result register lets the next transaction enter while a result waits
// after reset the NODES*NODES-entry link table is zeroed at one entry per cycle,
// with item_i not ready meanwhile
// a stalled result_o holds the update step until the result register frees
`include "assert_macros.svh"

module link_loss_smoother_hysteresis #(
  parameter int NODES = lls_pkg::NODES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  lls_stream_if.sink   item_i,
  lls_stream_if.source result_o,
  lls_stream_if.sink   cfg_i
);

  localparam int LinkCount = NODES * NODES;
  localparam int AW = $clog2(LinkCount);
  localparam int IW = lls_pkg::ID_W;
  localparam int LW = lls_pkg::LOSS_W;
  localparam int WW = lls_pkg::WEIGHT_W;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_READ    = 3'd1;
  localparam logic [2:0] S_MUL_NEW = 3'd2;
  localparam logic [2:0] S_MUL_OLD = 3'd3;
  localparam logic [2:0] S_UPD     = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [WW-1:0] ema_weight_q;
  logic [LW-1:0] block_thr_q, clear_thr_q;
  logic [LW-1:0] report_q;
  logic [AW-1:0] idx_q;
  logic          out_valid_q;
  lls_pkg::result_t result_q;

  logic             clear_busy;
  lls_pkg::entry_t  rd_entry;
  lls_pkg::entry_t  wr_entry;
  lls_pkg::mac_op_t mac_op;
  logic [WW-1:0]    mul_a;
  logic [LW-1:0]    mul_b;
  logic [lls_pkg::ACC_W-1:0] acc;
  logic [WW-1:0]    w_sat;
  logic [LW-1:0]    new_loss;
  logic             new_blocked;
  logic             item_acc, out_free, upd_go;
  logic [IW-1:0]    id_a, id_b, id_lo, id_hi;
  logic [AW-1:0]    link_idx;

  // id modulo NODES by restoring subtraction, ids are only 4 bits wide
  function automatic logic [IW-1:0] mod_nodes(input logic [IW-1:0] x);
    logic [IW-1:0] r;
    r = x;
    for (int k = 3; k >= 0; k--) begin
      if (int'(r) >= (NODES << k)) begin
        r = r - IW'(NODES << k);
      end
    end
    return r;
  endfunction

  assign id_a     = mod_nodes(item_i.data.node_a);
  assign id_b     = mod_nodes(item_i.data.node_b);
  assign id_lo    = (id_a < id_b) ? id_a : id_b;
  assign id_hi    = (id_a < id_b) ? id_b : id_a;
  assign link_idx = AW'(AW'(id_lo) * AW'(NODES) + AW'(id_hi));

  assign item_i.ready = (state_q == S_IDLE) && !clear_busy;
  assign item_acc     = item_i.valid && item_i.ready;
  assign out_free     = !out_valid_q || result_o.ready;
  assign upd_go       = (state_q == S_UPD) && out_free;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ema_weight_q <= lls_pkg::EMA_WEIGHT_RST;
      block_thr_q  <= lls_pkg::BLOCK_THRESHOLD_RST;
      clear_thr_q  <= lls_pkg::CLEAR_THRESHOLD_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.data.index)
        lls_pkg::REG_EMA_WEIGHT:      ema_weight_q <= cfg_i.data.wdata[WW-1:0];
        lls_pkg::REG_BLOCK_THRESHOLD: block_thr_q  <= cfg_i.data.wdata;
        lls_pkg::REG_CLEAR_THRESHOLD: clear_thr_q  <= cfg_i.data.wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (item_acc) state_d = S_READ;
      S_READ:    state_d = S_MUL_NEW;
      S_MUL_NEW: state_d = S_MUL_OLD;
      S_MUL_OLD: state_d = S_UPD;
      S_UPD:     if (out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_acc) begin
      report_q <= item_i.data.reported_loss;
      idx_q    <= link_idx;
    end
  end

  // weight above one saturates
  assign w_sat = (ema_weight_q > lls_pkg::WEIGHT_ONE) ? lls_pkg::WEIGHT_ONE : ema_weight_q;

  // first pass w*report, second pass adds (256-w)*old
  always_comb begin
    mac_op.en      = (state_q == S_MUL_NEW) || (state_q == S_MUL_OLD);
    mac_op.acc_clr = (state_q == S_MUL_NEW);
    if (state_q == S_MUL_NEW) begin
      mul_a = w_sat;
      mul_b = report_q;
    end else begin
      mul_a = lls_pkg::WEIGHT_ONE - w_sat;
      mul_b = rd_entry.loss;
    end
  end

  lls_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .op_i    (mac_op),
    .mul_a_i (mul_a),
    .mul_b_i (mul_b),
    .acc_o   (acc)
  );

  assign new_loss = acc[8 +: LW];

  // hysteresis: only one direction of change per update
  always_comb begin
    new_blocked = rd_entry.blocked;
    if (!rd_entry.blocked && (new_loss > block_thr_q)) begin
      new_blocked = 1'b1;
    end else if (rd_entry.blocked && (new_loss < clear_thr_q)) begin
      new_blocked = 1'b0;
    end
  end

  assign wr_entry.loss    = new_loss;
  assign wr_entry.blocked = new_blocked;

  lls_store #(
    .NODES (NODES)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (upd_go),
    .waddr_i (idx_q),
    .wdata_i (wr_entry),
    .re_i    (state_q == S_READ),
    .raddr_i (idx_q),
    .rdata_o (rd_entry),
    .busy_o  (clear_busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (upd_go) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_go) begin
      result_q.smoothed_loss <= new_loss;
      result_q.link_blocked  <= new_blocked;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = result_q;

  // the average never exceeds the larger of report and old value
  `LLS_ASSERT_IMP(a_ema_bounded, clk_i, rst_ni, upd_go,
                  (new_loss <= report_q) || (new_loss <= rd_entry.loss))
  // a link only turns blocked above the block threshold
  `LLS_ASSERT_IMP(a_block_above, clk_i, rst_ni, upd_go && new_blocked && !rd_entry.blocked,
                  new_loss > block_thr_q)
  // a link only turns clear below the clear threshold
  `LLS_ASSERT_IMP(a_clear_below, clk_i, rst_ni, upd_go && !new_blocked && rd_entry.blocked,
                  new_loss < clear_thr_q)
  // an accepted transaction goes straight to the table read
  `LLS_ASSERT_NXT(a_accept_reads, clk_i, rst_ni, item_acc, state_q == S_READ)

endmodule
